// ===== hw/rtl/cqir_pkg.sv =====
// Shared types and codes for the collapsing queue with indexed removal.
// Holds the command and status codes, the transfer structs and the cell control struct.
// No dependencies.
package cqir_pkg;

    // Command codes carried by an input transfer
    localparam logic [2:0] CMD_APPEND    = 3'd0;
    localparam logic [2:0] CMD_POP_HEAD  = 3'd1;
    localparam logic [2:0] CMD_READ_HEAD = 3'd2;
    localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
    localparam logic [2:0] CMD_POP_AT    = 3'd4;

    // Status codes returned with each result
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    // Input transfer payload
    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] data_in;
        logic [3:0]  index;
    } t_in_item;

    // Result transfer payload
    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic [4:0]  count;
    } t_out_item;

    // Per-cell control from the row controller
    typedef struct packed {
        logic shift;  // take the word of the next cell toward the tail
        logic load;   // take the appended word
        logic pick;   // present the held word on the read bus
    } t_cell_ctl;

endpackage

// ===== hw/rtl/collapsing_queue_with_indexed_removal_unit.sv =====
// Top level of the collapsing queue with indexed removal.
// Depends on cqir_pkg and instantiates a row of cqir_cell.
//
// Usage:
//   An ordered list of up to DEPTH words, packed from the head. A command
//   transfer is taken at a rising edge with start high and busy low; busy is
//   always low, so a new command may be issued in every cycle.
//   Commands: append at tail, remove head, read head, remove tail, remove at
//   index. A removal closes up every entry behind it in the same cycle, each
//   cell of the row taking the word of its neighbor toward the tail.
//   Latency: the result (word touched, status, count after the command) is on
//   o_result in the cycle after the command is taken, marked by o_strobe for
//   exactly one cycle, and held until the next command. Throughput: one command
//   per cycle, as the cell row and the count register update when it is taken.
//   Refused commands (append when full, removal or read when empty, index at
//   or beyond the count) return data zero and change nothing.
//   Reset clears the count and the strobe; the words of the cells are not
//   cleared, since only positions below the count are ever read.
//   The receiver cannot stall: each result is taken in the cycle it is shown.
module collapsing_queue_with_indexed_removal_unit
    import cqir_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int HW = $clog2(DEPTH + 1);
    localparam int CW = (HW > 4) ? HW : 4;

    logic [HW-1:0]         r_held;
    logic [HW-1:0]         n_held;
    logic                  r_strobe;
    t_out_item             r_result;
    t_out_item             n_result;
    logic [1:0]            n_status;

    logic                  accept;
    logic                  empty;
    logic                  full;
    logic [CW-1:0]         idx_w;
    logic [CW-1:0]         held_w;
    logic                  do_append;
    logic                  do_remove;
    logic                  do_read;
    logic [HW-1:0]         pos;
    logic [DATA_WIDTH-1:0] append_word;
    logic [DATA_WIDTH-1:0] read_word;

    t_cell_ctl             cell_ctl  [DEPTH];
    logic [DATA_WIDTH-1:0] cell_word [DEPTH];
    logic [DATA_WIDTH-1:0] cell_pick [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign empty  = (r_held == '0);
    assign full   = (r_held == HW'(DEPTH));
    assign idx_w  = CW'(i_item.index);
    assign held_w = CW'(r_held);
    assign append_word = DATA_WIDTH'(i_item.data_in);

    // Decode the command into one row operation and its status
    always_comb begin
        do_append = 1'b0;
        do_remove = 1'b0;
        do_read   = 1'b0;
        pos       = '0;
        n_status  = ST_OK;
        unique case (i_item.command)
            CMD_APPEND: begin
                if (full) n_status = ST_FULL;
                else      do_append = accept;
            end
            CMD_POP_HEAD: begin
                if (empty) n_status = ST_EMPTY;
                else       do_remove = accept;
            end
            CMD_READ_HEAD: begin
                if (empty) n_status = ST_EMPTY;
                else       do_read = accept;
            end
            CMD_POP_TAIL: begin
                pos = r_held - HW'(1);
                if (empty) n_status = ST_EMPTY;
                else       do_remove = accept;
            end
            CMD_POP_AT: begin
                pos = HW'(idx_w);
                if (empty)                n_status = ST_EMPTY;
                else if (idx_w >= held_w) n_status = ST_BAD_INDEX;
                else                      do_remove = accept;
            end
            default: begin
            end
        endcase
    end

    // Drive each cell: close up behind the removed position, load at the tail
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            cell_ctl[k].shift = do_remove && (HW'(k) >= pos);
            cell_ctl[k].load  = do_append && (HW'(k) == r_held);
            cell_ctl[k].pick  = (do_remove || do_read) && (HW'(k) == pos);
        end
    end

    // Build the row of cells, each fed by its neighbor toward the tail
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] next_word;
        if (g == DEPTH - 1) begin : g_last
            assign next_word = '0;
        end else begin : g_inner
            assign next_word = cell_word[g+1];
        end
        cqir_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl[g]),
            .i_append_word (append_word),
            .i_next_word   (next_word),
            .o_word        (cell_word[g]),
            .o_pick_word   (cell_pick[g])
        );
    end

    // Merge the selected cell onto the read bus
    always_comb begin
        read_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            read_word = read_word | cell_pick[k];
        end
    end

    // Compute the next count and the result
    always_comb begin
        n_held = r_held;
        if (do_append)      n_held = r_held + HW'(1);
        else if (do_remove) n_held = r_held - HW'(1);
        n_result.data_out = 32'(read_word);
        n_result.status   = n_status;
        n_result.count    = 5'(n_held);
    end

    // Hold count, strobe and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_held   <= n_held;
            r_strobe <= accept;
        end
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Count never exceeds the row length
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(DEPTH))
        else $error("count exceeds depth");

    // Every taken command gives exactly one strobed result in the next cycle
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("missing result strobe");

    // Reported count matches the held count
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.count == 5'(r_held)))
        else $error("reported count differs from held count");

    // A full status is only given on a full row
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == ST_FULL)) |-> full)
        else $error("full status on a row with room");

    // A refused command leaves the count alone
    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (n_status != ST_OK)) |=> (r_held == $past(r_held)))
        else $error("refused command changed the count");

endmodule

// ===== hw/rtl/cqir_cell.sv =====
// One storage cell of the collapsing row: holds one word and closes up from its neighbor.
// Depends on cqir_pkg for the cell control struct.
module cqir_cell
    import cqir_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [DATA_WIDTH-1:0] i_append_word,
    input  logic [DATA_WIDTH-1:0] i_next_word,
    output logic [DATA_WIDTH-1:0] o_word,
    output logic [DATA_WIDTH-1:0] o_pick_word
);

    logic [DATA_WIDTH-1:0] r_word;

    // Load an appended word or advance the neighbor's word toward the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_word <= i_append_word;
        end else if (i_ctl.shift) begin
            r_word <= i_next_word;
        end
    end

    assign o_word      = r_word;
    // Gate the held word onto the read bus only when selected
    assign o_pick_word = i_ctl.pick ? r_word : '0;

endmodule

// ===== test/collapsing_queue_with_indexed_removal_unit_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the collapsing queue with indexed removal.
// Keeps a shadow copy of the list, predicts each result and compares it field by field.
// Depends on cqir_pkg.
module collapsing_queue_with_indexed_removal_unit_checker
    import cqir_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  logic      busy,
    input  t_in_item  i_item,
    input  logic      i_strobe,
    input  t_out_item i_result,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the list contents and fill level
    logic [31:0] shadow_words [DEPTH];
    int          shadow_held;
    t_out_item   expected_results [$];

    // Take the word at pos and close up the entries behind it
    function automatic logic [31:0] take_word(input int pos);
        logic [31:0] word;
        word = shadow_words[pos];
        for (int k = pos; k + 1 < shadow_held; k++) begin
            shadow_words[k] = shadow_words[k + 1];
        end
        shadow_held--;
        return word;
    endfunction

    // Apply one command to the shadow list and return the result it gives
    function automatic t_out_item queue_apply(input t_in_item cmd);
        t_out_item res;
        res = '0;
        unique case (cmd.command)
            CMD_APPEND: begin
                if (shadow_held >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_words[shadow_held] = cmd.data_in;
                    shadow_held++;
                end
            end
            CMD_POP_HEAD: begin
                if (shadow_held == 0) res.status = ST_EMPTY;
                else res.data_out = take_word(0);
            end
            CMD_READ_HEAD: begin
                if (shadow_held == 0) res.status = ST_EMPTY;
                else res.data_out = shadow_words[0];
            end
            CMD_POP_TAIL: begin
                if (shadow_held == 0) res.status = ST_EMPTY;
                else res.data_out = take_word(shadow_held - 1);
            end
            CMD_POP_AT: begin
                // empty check wins over the index check
                if (shadow_held == 0) res.status = ST_EMPTY;
                else if (int'(cmd.index) >= shadow_held) res.status = ST_BAD_INDEX;
                else res.data_out = take_word(int'(cmd.index));
            end
            default: ;
        endcase
        res.count = 5'(shadow_held);
        return res;
    endfunction

    // Count a failure and report the first few
    function automatic void flag_failure(input string what, input t_out_item exp_res,
                                         input t_out_item act_res);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected data %h status %0d count %0d,",
                     $time, what, exp_res.data_out, exp_res.status, exp_res.count,
                     " got data %h status %0d count %0d",
                     act_res.data_out, act_res.status, act_res.count);
        end
    endfunction

    initial begin
        o_fail_count = 0;
        shadow_held  = 0;
    end

    assign o_pending = expected_results.size();

    // Check the result shown this cycle, then predict for the command taken at this edge
    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (!i_rst_n) begin
            shadow_held = 0;
            expected_results.delete();
        end else begin
            if (i_strobe !== 1'b0) begin
                if (expected_results.size() == 0) begin
                    flag_failure("unexpected result", '0, i_result);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_strobe !== 1'b1
                        || i_result.data_out !== exp_res.data_out
                        || i_result.status !== exp_res.status
                        || i_result.count !== exp_res.count) begin
                        flag_failure("result mismatch", exp_res, i_result);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                expected_results.push_back(queue_apply(i_item));
            end
        end
    end

endmodule

// ===== test/collapsing_queue_with_indexed_removal_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the collapsing queue with indexed removal.
// Drives directed and random command transfers; depends on cqir_pkg, the unit and its checker.
module collapsing_queue_with_indexed_removal_unit_tb;
    import cqir_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT = 200000;

    // Command values the unit treats as no-ops
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    t_in_item  cmd_item;
    logic      strobe;
    t_out_item result;
    int        fail_count;
    int        pending;
    int        cycle_count;
    int        sender_idle_pct;

    collapsing_queue_with_indexed_removal_unit #(
        .DEPTH     (DEPTH),
        .DATA_WIDTH(32)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (cmd_item),
        .o_strobe(strobe),
        .o_result(result)
    );

    collapsing_queue_with_indexed_removal_unit_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (cmd_item),
        .i_strobe    (strobe),
        .i_result    (result),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_in_item make_cmd(input logic [2:0] command, input logic [31:0] data,
                                          input logic [3:0] index);
        t_in_item item;
        item.command = command;
        item.data_in = data;
        item.index   = index;
        return item;
    endfunction

    // Random command; append_pct sets how hard the list is pushed toward full
    function automatic t_in_item random_cmd(input int append_pct);
        t_in_item item;
        int       pick;
        item.data_in = $urandom();
        item.index   = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 31);
        if (pick == 0) item.data_in = '0;
        else if (pick == 1) item.data_in = '1;
        if ($urandom_range(0, 99) < append_pct) begin
            item.command = CMD_APPEND;
        end else begin
            pick = $urandom_range(0, 19);
            if (pick < 5) item.command = CMD_POP_HEAD;
            else if (pick < 9) item.command = CMD_READ_HEAD;
            else if (pick < 13) item.command = CMD_POP_TAIL;
            else if (pick < 19) item.command = CMD_POP_AT;
            else begin
                case ($urandom_range(0, 2))
                    0: item.command = CMD_SPARE_A;
                    1: item.command = CMD_SPARE_B;
                    default: item.command = CMD_SPARE_C;
                endcase
            end
        end
        return item;
    endfunction

    // Present one command after idle cycles drawn per cycle, and hold it until the transfer
    task automatic issue(input t_in_item item);
        @(negedge clk);
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        cmd_item <= item;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    initial begin
        int append_pct;
        int waited;
        rst_n           = 1'b0;
        start           = 1'b0;
        cmd_item        = '0;
        sender_idle_pct = 10;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty list: every removal and read is refused
        issue(make_cmd(CMD_POP_HEAD, 32'h0, 4'd0));
        issue(make_cmd(CMD_READ_HEAD, 32'h0, 4'd0));
        issue(make_cmd(CMD_POP_TAIL, 32'h0, 4'd0));
        issue(make_cmd(CMD_POP_AT, 32'hFFFF_FFFF, 4'd15));
        issue(make_cmd(CMD_SPARE_C, 32'hFFFF_FFFF, 4'd15));
        // Fill to the top with extreme and mixed words, then overfill
        issue(make_cmd(CMD_APPEND, 32'h0000_0000, 4'd15));
        issue(make_cmd(CMD_APPEND, 32'hFFFF_FFFF, 4'd0));
        for (int k = 2; k < DEPTH; k++) begin
            issue(make_cmd(CMD_APPEND, {16'(k), 16'hA5C3 ^ 16'(k)}, 4'd0));
        end
        issue(make_cmd(CMD_APPEND, 32'hDEAD_BEEF, 4'd0));
        issue(make_cmd(CMD_READ_HEAD, 32'h0, 4'd0));
        // Indexed removal at the tail, past the new tail, at the head and inside; then tail and head removal
        issue(make_cmd(CMD_POP_AT, 32'h0, 4'd15));
        issue(make_cmd(CMD_POP_AT, 32'h0, 4'd15));
        issue(make_cmd(CMD_POP_AT, 32'h0, 4'd0));
        issue(make_cmd(CMD_POP_AT, 32'h0, 4'd6));
        issue(make_cmd(CMD_POP_TAIL, 32'h0, 4'd0));
        issue(make_cmd(CMD_POP_HEAD, 32'h0, 4'd0));

        // Random traffic in three idling phases, with the fill pressure changing per chunk
        append_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) sender_idle_pct = 72;
            if (n == 2 * RANDOM_ITEMS / 3) sender_idle_pct = 0;
            if (n % 40 == 0) append_pct = $urandom_range(20, 80);
            issue(random_cmd(append_pct));
        end
        @(negedge clk);
        start <= 1'b0;

        // Drain outstanding results, then idle before reporting the status
        waited = 0;
        while (pending != 0 && waited < 100) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
